/* rtl/core/lsog_pkg.sv */
// ----------------------------------------------------------------------------
// lsog_pkg
// shared types and constants of the laser scan occupancy grid
// ----------------------------------------------------------------------------
`default_nettype none

package lsog_pkg;

    // default grid edge in cells
    localparam int GRID_BLOCKS_DEF = 128;

    // input opcodes
    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_BEAM  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CELL_SIZE  = 2'd0,
        CFG_INFLATION  = 2'd1,
        CFG_FIRST_BEAM = 2'd2,
        CFG_BEAM_STEP  = 2'd3
    } t_cfg_index;

    // configuration reset values
    localparam logic [15:0] CELL_SIZE_RST  = 16'd102;
    localparam logic [15:0] INFLATION_RST  = 16'd205;
    localparam logic [15:0] FIRST_BEAM_RST = 16'h8000;
    localparam logic [15:0] BEAM_STEP_RST  = 16'd64;

    // lidar mount offset, 0.275 m in q.10
    localparam logic [16:0] LIDAR_OFFSET = 17'd282;

    // sine polynomial coefficients, q14
    localparam logic [16:0] SIN_C1 = 17'd1160;
    localparam logic [14:0] SIN_C2 = 15'd10512;
    localparam logic [14:0] SIN_C3 = 15'd25736;
    localparam logic [14:0] QUARTER = 15'd16384;

    // divider width in bits
    localparam int DIV_W = 18;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ANG,
        S_ANG_SUM,
        S_TRIG_SQ,
        S_TRIG_C1,
        S_TRIG_C2,
        S_TRIG_C3,
        S_TRIG_C4,
        S_TRIG_SC,
        S_ORIGIN,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_DIV_END,
        S_SPAN_MUL,
        S_SPAN_GET,
        S_FILL_SET,
        S_FILL,
        S_QREAD,
        S_QOUT
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/lsog_ram.sv */
// ----------------------------------------------------------------------------
// lsog_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lsog_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/laser_scan_occupancy_grid_unit.sv */
// ----------------------------------------------------------------------------
// laser_scan_occupancy_grid_unit
// lidar occupancy grid with obstacle inflation, iterative datapath
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall with opcode and payload fields.
//   an item is taken at a clock edge with valid high and stall low.
//   new scan: stores heading, origin and restarts the beam count, then
//     clears the bitmap one cell per cycle.
//   beam: math with two trig evaluations on the shared multiplier and
//     five divisions on the serial divider, then marks one cell of the
//     inflated square per cycle.
//   query: read in S_QREAD, result from S_QOUT on o_out_valid / i_out_stall.
//   item time is set by the single multiplier, the bit-serial divider and
//   the single ram write port; one item is in work at a time.
//   output register holds a result while the receiver stalls; the next
//   item can be taken meanwhile, and a later query waits for the slot.
//   reset (synchronous, active low) restores the control and config
//   registers and runs the bitmap clearing pass with o_in_stall high.
//   config writes (i_cfg_we) take effect at once; write them only while
//   the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_occupancy_grid_unit
    import lsog_pkg::*;
#(
    parameter int GRID_BLOCKS = GRID_BLOCKS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    // input items
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_opcode,
    input  wire logic signed [23:0] i_pose_x,
    input  wire logic signed [23:0] i_pose_y,
    input  wire logic signed [15:0] i_heading,
    input  wire logic [15:0]        i_beam_range,
    input  wire logic [7:0]         i_query_row,
    input  wire logic [7:0]         i_query_col,
    // result items
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_occupied
);

    localparam int CELLS = GRID_BLOCKS * GRID_BLOCKS;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(GRID_BLOCKS);
    localparam logic signed [19:0] HALF_GRID = 20'(GRID_BLOCKS / 2);
    localparam logic signed [19:0] LAST_IDX  = 20'(GRID_BLOCKS - 1);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(CELLS - 1);

    // configuration registers
    logic [15:0] r_cell_size, r_inflation, r_first_beam, r_beam_step;

    // scan state
    logic signed [23:0] r_origin_x, r_origin_y;
    logic signed [23:0] r_pose_x, r_pose_y;
    logic [15:0]        r_scan_heading;
    logic [15:0]        r_beam_count;

    // sequencer
    t_state r_state, n_state;
    logic   r_is_scan;
    logic   r_phase;            // 0 cosine, 1 sine
    logic [15:0] r_angle;
    logic [15:0] r_range;

    // shared multiplier
    logic [16:0] mul_a, mul_b;
    logic [33:0] r_prod;
    logic [14:0] r_z2;
    logic signed [17:0] r_dx, r_dy;

    // serial divider
    logic [2:0]        r_div_sel;
    logic [4:0]        r_dcnt;
    logic [DIV_W-1:0]  r_quo;
    logic [15:0]       r_rem;
    logic              r_qneg;
    logic [16:0]       r_steps;
    logic [16:0]       r_span;
    logic signed [19:0] r_xa, r_xb, r_ya, r_yb;

    // fill walk
    logic [IW-1:0] r_row, r_col, r_row_hi, r_col_lo, r_col_hi;

    // memory access
    logic [AW-1:0] r_addr;
    logic          r_qin;
    logic          r_out_valid, r_occupied;
    logic          ram_we, ram_wd, ram_q;
    logic [AW-1:0] ram_wr_addr, fill_addr;

    // ------------------------------------------------------------------
    // combinational datapath pieces
    // ------------------------------------------------------------------
    logic        in_acc;
    logic [15:0] cs_eff;
    logic [15:0] ang_eff;
    logic [14:0] trig_z;
    logic        trig_neg;
    logic [14:0] z2_now, t1_now, t2_now, f_now;
    logic [16:0] mag_now;
    logic signed [17:0] scaled;
    logic signed [24:0] org_x_sum, org_y_sum;
    logic signed [19:0] num_s, q_s, idx_s;
    logic [19:0]        num_mag;
    logic [16:0]        rem_sh, rem_sub;
    logic               div_bit;
    logic signed [19:0] x_lo, x_hi, y_lo, y_hi;
    logic               out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign cs_eff   = (r_cell_size == 16'd0) ? 16'd1 : r_cell_size;
    assign ang_eff  = r_phase ? r_angle : r_angle + 16'h4000;
    assign trig_z   = ang_eff[14] ? (QUARTER - {1'b0, ang_eff[13:0]})
                                  : {1'b0, ang_eff[13:0]};
    assign trig_neg = ang_eff[15];

    // polynomial stages, each reads the previous product
    assign z2_now  = r_prod[28:14];
    assign t1_now  = SIN_C2 - {4'd0, r_prod[24:14]};
    assign t2_now  = SIN_C3 - {1'b0, r_prod[27:14]};
    assign f_now   = r_prod[28:14];
    // round to nearest, half away from zero, on the magnitude
    assign mag_now = 17'((r_prod + 34'd8192) >> 14);
    assign scaled  = trig_neg ? -$signed({1'b0, mag_now}) : $signed({1'b0, mag_now});

    assign org_x_sum = 25'(r_pose_x) + 25'(r_dx);
    assign org_y_sum = 25'(r_pose_y) + 25'(r_dy);

    // divider numerators
    always_comb begin
        unique case (r_div_sel)
            3'd0:    num_s = $signed({3'd0, r_inflation, 1'b0});
            3'd1:    num_s = 20'(r_dx) - $signed({4'd0, r_inflation});
            3'd2:    num_s = 20'(r_dx) - $signed({4'd0, r_inflation})
                             + $signed({3'd0, r_span});
            3'd3:    num_s = 20'(r_dy) - $signed({4'd0, r_inflation});
            default: num_s = 20'(r_dy) - $signed({4'd0, r_inflation})
                             + $signed({3'd0, r_span});
        endcase
        num_mag = num_s[19] ? 20'(-num_s) : 20'(num_s);
    end

    assign rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign div_bit = (rem_sh >= {1'b0, cs_eff});
    assign rem_sub = rem_sh - {1'b0, cs_eff};

    // truncated quotient, shifted to grid index
    assign q_s   = r_qneg ? -$signed({2'd0, r_quo}) : $signed({2'd0, r_quo});
    assign idx_s = q_s + HALF_GRID;

    // clip spans to the grid
    assign x_lo = r_xa[19] ? 20'sd0 : r_xa;
    assign x_hi = (r_xb > LAST_IDX) ? LAST_IDX : r_xb;
    assign y_lo = r_ya[19] ? 20'sd0 : r_ya;
    assign y_hi = (r_yb > LAST_IDX) ? LAST_IDX : r_yb;

    assign fill_addr = AW'(int'(r_row) * GRID_BLOCKS + int'(r_col));
    assign out_free  = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_opcode'(i_opcode))
                        OP_SCAN:  n_state = S_TRIG_SQ;
                        OP_BEAM:  n_state = S_ANG;
                        OP_QUERY: n_state = S_QREAD;
                        OP_NOP:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ANG:      n_state = S_ANG_SUM;
            S_ANG_SUM:  n_state = S_TRIG_SQ;
            S_TRIG_SQ:  n_state = S_TRIG_C1;
            S_TRIG_C1:  n_state = S_TRIG_C2;
            S_TRIG_C2:  n_state = S_TRIG_C3;
            S_TRIG_C3:  n_state = S_TRIG_C4;
            S_TRIG_C4:  n_state = S_TRIG_SC;
            S_TRIG_SC: begin
                priority if (!r_phase) n_state = S_TRIG_SQ;
                else if (r_is_scan)    n_state = S_ORIGIN;
                else                   n_state = S_DIV_LOAD;
            end
            S_ORIGIN:   n_state = S_CLEAR;
            S_DIV_LOAD: n_state = S_DIV_RUN;
            S_DIV_RUN:  if (r_dcnt == 5'(DIV_W - 1)) n_state = S_DIV_END;
            S_DIV_END: begin
                priority if (r_div_sel == 3'd0) n_state = S_SPAN_MUL;
                else if (r_div_sel == 3'd4)     n_state = S_FILL_SET;
                else                            n_state = S_DIV_LOAD;
            end
            S_SPAN_MUL: n_state = S_SPAN_GET;
            S_SPAN_GET: n_state = S_DIV_LOAD;
            S_FILL_SET: begin
                if (x_lo <= x_hi && y_lo <= y_hi) n_state = S_FILL;
                else                              n_state = S_IDLE;
            end
            S_FILL:     if (r_col == r_col_hi && r_row == r_row_hi) n_state = S_IDLE;
            S_QREAD:    n_state = S_QOUT;
            S_QOUT:     if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // multiplier operands and ram control
    // ------------------------------------------------------------------
    always_comb begin
        mul_a       = 17'd0;
        mul_b       = 17'd0;
        ram_we      = 1'b0;
        ram_wd      = 1'b0;
        ram_wr_addr = fill_addr;
        unique case (r_state)
            S_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_addr;
            end
            S_ANG: begin
                mul_a = {1'b0, r_beam_count};
                mul_b = {1'b0, r_beam_step};
            end
            S_TRIG_SQ: begin
                mul_a = {2'd0, trig_z};
                mul_b = {2'd0, trig_z};
            end
            S_TRIG_C1: begin
                mul_a = SIN_C1;
                mul_b = {2'd0, z2_now};
            end
            S_TRIG_C2: begin
                mul_a = {2'd0, t1_now};
                mul_b = {2'd0, r_z2};
            end
            S_TRIG_C3: begin
                mul_a = {2'd0, t2_now};
                mul_b = {2'd0, trig_z};
            end
            S_TRIG_C4: begin
                mul_a = r_is_scan ? LIDAR_OFFSET : {1'b0, r_range};
                mul_b = {2'd0, f_now};
            end
            S_SPAN_MUL: begin
                mul_a = r_steps;
                mul_b = {1'b0, cs_eff};
            end
            S_FILL: begin
                ram_we = 1'b1;
                ram_wd = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_addr         <= '0;
            r_cell_size    <= CELL_SIZE_RST;
            r_inflation    <= INFLATION_RST;
            r_first_beam   <= FIRST_BEAM_RST;
            r_beam_step    <= BEAM_STEP_RST;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_scan_heading <= '0;
            r_beam_count   <= '0;
            r_out_valid    <= 1'b0;
            r_phase        <= 1'b0;
            r_is_scan      <= 1'b0;
            r_div_sel      <= '0;
            r_dcnt         <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_CELL_SIZE:  r_cell_size  <= i_cfg_data;
                    CFG_INFLATION:  r_inflation  <= i_cfg_data;
                    CFG_FIRST_BEAM: r_first_beam <= i_cfg_data;
                    CFG_BEAM_STEP:  r_beam_step  <= i_cfg_data;
                endcase
            end

            // result slot: load a query answer, or empty once taken
            if (r_state == S_QOUT && out_free) begin
                r_out_valid <= 1'b1;
                r_occupied  <= r_qin & ram_q;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: r_addr <= r_addr + AW'(1);
                S_IDLE: begin
                    if (in_acc) begin
                        r_phase   <= 1'b0;
                        r_is_scan <= (t_opcode'(i_opcode) == OP_SCAN);
                        r_range   <= i_beam_range;
                        r_addr    <= AW'(int'(i_query_row) * GRID_BLOCKS
                                         + int'(i_query_col));
                        r_qin     <= (int'(i_query_row) < GRID_BLOCKS)
                                  && (int'(i_query_col) < GRID_BLOCKS);
                        if (t_opcode'(i_opcode) == OP_SCAN) begin
                            r_scan_heading <= i_heading;
                            r_angle        <= i_heading;
                            r_beam_count   <= '0;
                            r_pose_x       <= i_pose_x;
                            r_pose_y       <= i_pose_y;
                        end
                    end
                end
                S_ANG: begin
                end
                S_ANG_SUM: begin
                    r_angle      <= r_prod[15:0] + r_first_beam + r_scan_heading;
                    r_beam_count <= r_beam_count + 16'd1;
                end
                S_TRIG_C1: r_z2 <= z2_now;
                S_TRIG_SC: begin
                    if (!r_phase) r_dx <= scaled;
                    else          r_dy <= scaled;
                    r_phase   <= 1'b1;
                    r_div_sel <= '0;
                end
                S_ORIGIN: begin
                    // saturate to 24 bit signed
                    priority if (org_x_sum > 25'sd8388607)  r_origin_x <= 24'sh7FFFFF;
                    else if (org_x_sum < -25'sd8388608)     r_origin_x <= 24'sh800000;
                    else                                    r_origin_x <= org_x_sum[23:0];
                    priority if (org_y_sum > 25'sd8388607)  r_origin_y <= 24'sh7FFFFF;
                    else if (org_y_sum < -25'sd8388608)     r_origin_y <= 24'sh800000;
                    else                                    r_origin_y <= org_y_sum[23:0];
                    r_addr <= '0;
                end
                S_DIV_LOAD: begin
                    r_quo  <= num_mag[DIV_W-1:0];
                    r_rem  <= '0;
                    r_qneg <= num_s[19];
                    r_dcnt <= '0;
                end
                S_DIV_RUN: begin
                    r_rem  <= div_bit ? rem_sub[15:0] : rem_sh[15:0];
                    r_quo  <= {r_quo[DIV_W-2:0], div_bit};
                    r_dcnt <= r_dcnt + 5'd1;
                end
                S_DIV_END: begin
                    unique case (r_div_sel)
                        3'd0:    r_steps <= r_quo[16:0];
                        3'd1:    r_xa    <= idx_s;
                        3'd2:    r_xb    <= idx_s;
                        3'd3:    r_ya    <= idx_s;
                        default: r_yb    <= idx_s;
                    endcase
                    if (r_div_sel != 3'd0) r_div_sel <= r_div_sel + 3'd1;
                end
                S_SPAN_GET: begin
                    r_span    <= r_prod[16:0];
                    r_div_sel <= 3'd1;
                end
                S_FILL_SET: begin
                    r_row    <= y_lo[IW-1:0];
                    r_row_hi <= y_hi[IW-1:0];
                    r_col    <= x_lo[IW-1:0];
                    r_col_lo <= x_lo[IW-1:0];
                    r_col_hi <= x_hi[IW-1:0];
                end
                S_FILL: begin
                    if (r_col == r_col_hi) begin
                        r_col <= r_col_lo;
                        r_row <= r_row + IW'(1);
                    end else begin
                        r_col <= r_col + IW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    lsog_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wd),
        .i_rd_addr (r_addr),
        .o_rd_data (ram_q)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_occupied  = r_occupied;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_QOUT)
        else $error("result item without a query");

    a_fill_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FILL |-> (r_row <= r_row_hi) && (r_col <= r_col_hi)
                              && (r_col >= r_col_lo))
        else $error("fill walk left its square");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV_RUN |-> r_dcnt < 5'(DIV_W))
        else $error("divider ran past its width");

    a_reset_clears: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> r_state == S_CLEAR)
        else $error("reset did not start the clearing pass");

endmodule

`default_nettype wire

/* sim/laser_scan_occupancy_grid_unit_tb.sv */
// ----------------------------------------------------------------------------
// laser_scan_occupancy_grid_unit_tb
// self-checking bench for the lidar occupancy grid with obstacle inflation:
// scan, beam and query items go in with random gaps, the bench keeps its own
// bitmap and answers every query ahead of the block, results are compared
// in order as they come out under random and long receiver stalls
// ----------------------------------------------------------------------------
`default_nettype none

module laser_scan_occupancy_grid_unit_tb;
    import lsog_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID = GRID_BLOCKS_DEF;
    localparam int HALF = GRID / 2;

    // clock, reset and block ports
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic signed [23:0] i_pose_x;
    logic signed [23:0] i_pose_y;
    logic signed [15:0] i_heading;
    logic [15:0]        i_beam_range;
    logic [7:0]         i_query_row;
    logic [7:0]         i_query_col;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_occupied;

    laser_scan_occupancy_grid_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // bench copy of the grid state and the registers
    bit                 grid_map [GRID*GRID];
    logic signed [23:0] grid_org_x, grid_org_y;
    logic [15:0]        scan_hdg, beam_idx;
    logic [15:0]        reg_cell, reg_infl, reg_first, reg_step;

    // expected answers of queries, oldest first
    bit                 occ_expected [$];
    int                 errors = 0;

    // center of the last marked square, for aiming queries
    int                 hit_row = HALF, hit_col = HALF;

    // idling controls
    bit                 send_busy_free = 0;  // sender never pauses
    bit                 recv_busy_free = 0;  // receiver never stalls
    int                 recv_hold = 0;       // long receiver hold, in cycles

    // random gap: mostly none or short, now and then long
    function automatic int gap_len(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // append one expected answer at the tail
    function automatic void queue_answer(bit v);
        occ_expected = {occ_expected, v};
    endfunction

    // q14 sine of a binary angle, polynomial per quarter turn
    function automatic longint sine_q14(logic [15:0] a);
        longint r, z, z2, t, v;
        r  = a[13:0];
        z  = a[14] ? 16384 - r : r;
        z2 = (z * z) >>> 14;
        t  = 10512 - ((1160 * z2) >>> 14);
        t  = 25736 - ((t * z2) >>> 14);
        v  = (t * z) >>> 14;
        return a[15] ? -v : v;
    endfunction

    // length times q14 trig, rounded half away from zero
    function automatic longint scale_q14(longint len, longint trig);
        longint p;
        p = len * trig;
        if (p >= 0) return (p + 8192) >>> 14;
        return -((-p + 8192) >>> 14);
    endfunction

    function automatic logic signed [23:0] clamp24(longint v);
        if (v > 8388607) return 24'sh7FFFFF;
        if (v < -8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    // index span of the inflated square on one axis, clipped to the grid
    function automatic bit span_of(longint rel, longint cs, longint infl,
                                   output int lo, output int hi);
        longint steps, a, b;
        steps = (2 * infl) / cs;
        a = (rel - infl) / cs + HALF;
        b = (rel - infl + steps * cs) / cs + HALF;
        if (a < 0) a = 0;
        if (b > GRID - 1) b = GRID - 1;
        lo = int'(a);
        hi = int'(b);
        return a <= b;
    endfunction

    // advance the bench grid by one accepted item
    task automatic grid_update(t_opcode op);
        longint cs, dx, dy;
        logic [15:0] ang;
        int c0, c1, r0, r1;
        case (op)
            OP_SCAN: begin
                grid_map   = '{default: 1'b0};
                scan_hdg   = i_heading;
                beam_idx   = '0;
                grid_org_x = clamp24(longint'(i_pose_x) +
                             scale_q14(282, sine_q14(i_heading + 16'd16384)));
                grid_org_y = clamp24(longint'(i_pose_y) +
                             scale_q14(282, sine_q14(i_heading)));
            end
            OP_BEAM: begin
                cs  = (reg_cell == 0) ? 1 : reg_cell;
                ang = reg_first + beam_idx * reg_step + scan_hdg;
                dx  = scale_q14(i_beam_range, sine_q14(ang + 16'd16384));
                dy  = scale_q14(i_beam_range, sine_q14(ang));
                beam_idx = beam_idx + 16'd1;
                if (span_of(dx, cs, reg_infl, c0, c1) &&
                    span_of(dy, cs, reg_infl, r0, r1)) begin
                    for (int r = r0; r <= r1; r++)
                        for (int c = c0; c <= c1; c++)
                            grid_map[r*GRID + c] = 1'b1;
                    hit_row = (r0 + r1) / 2;
                    hit_col = (c0 + c1) / 2;
                end
            end
            OP_QUERY: begin
                if (i_query_row < GRID && i_query_col < GRID)
                    queue_answer(grid_map[i_query_row*GRID + i_query_col]);
                else
                    queue_answer(1'b0);
            end
            default: ;  // no operation, no result
        endcase
    endtask

    // offer one item, all fields random unless the opcode uses them;
    // called at a clock edge, returns at the edge of acceptance or after a gap
    task automatic send_item(t_opcode op, logic [23:0] px, logic [23:0] py,
                             logic [15:0] hd, logic [15:0] rng,
                             logic [7:0] row, logic [7:0] col);
        int gap;
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_pose_x     <= px;
        i_pose_y     <= py;
        i_heading    <= hd;
        i_beam_range <= rng;
        i_query_row  <= row;
        i_query_col  <= col;
        do @(posedge i_clk); while (o_in_stall);
        grid_update(op);
        gap = gap_len(send_busy_free);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic scan(logic [23:0] px, logic [23:0] py, logic [15:0] hd);
        send_item(OP_SCAN, px, py, hd, $urandom, $urandom, $urandom);
    endtask

    task automatic beam(logic [15:0] rng);
        send_item(OP_BEAM, $urandom, $urandom, $urandom, rng, $urandom, $urandom);
    endtask

    task automatic query(logic [7:0] row, logic [7:0] col);
        send_item(OP_QUERY, $urandom, $urandom, $urandom, $urandom, row, col);
    endtask

    // query aimed near the last marked square, sometimes anywhere
    task automatic aimed_query();
        int r, c, k;
        k = $urandom_range(0, 99);
        if (k < 60) begin
            r = hit_row + $urandom_range(0, 8) - 4;
            c = hit_col + $urandom_range(0, 8) - 4;
        end else if (k < 85) begin
            r = $urandom_range(0, GRID - 1);
            c = $urandom_range(0, GRID - 1);
        end else begin
            r = $urandom_range(0, 255);
            c = $urandom_range(0, 255);
        end
        query(r[7:0], c[7:0]);
    endtask

    // a closing query makes the block finish all earlier work before it answers
    task automatic drain();
        query(HALF, HALF);
        i_in_valid <= 1'b0;
        while (occ_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // idle block only: write all four registers
    task automatic write_regs(logic [15:0] cs, logic [15:0] infl,
                              logic [15:0] first, logic [15:0] step);
        t_cfg_index idx [4] = '{CFG_CELL_SIZE, CFG_INFLATION, CFG_FIRST_BEAM,
                                CFG_BEAM_STEP};
        logic [15:0] val [4];
        val = '{cs, infl, first, step};
        drain();
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        reg_cell  = cs;
        reg_infl  = infl;
        reg_first = first;
        reg_step  = step;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (occ_expected.size() == 0)
                report_mismatch("result item with nothing expected");
            else if (o_occupied !== occ_expected[0]) begin
                report_mismatch($sformatf("occupied %b, expected %b",
                                          o_occupied, occ_expected[0]));
                void'(occ_expected.pop_front());
            end else
                void'(occ_expected.pop_front());
        end
    end

    // receiver: random stalls, or a long hold when asked
    initial begin
        int left;
        left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_stall <= 1'b1;
            end else if (left > 0) begin
                left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                left = gap_len(recv_busy_free);
            end
        end
    end

    // reset values, extremes of the query range, unused opcode
    task automatic test_after_reset();
        query(HALF, HALF);
        query(0, 0);
        query(GRID - 1, GRID - 1);
        query(GRID, 0);
        query(255, 255);
        send_item(OP_NOP, '1, '1, '1, '1, '1, '1);
        send_item(OP_NOP, '0, '0, '0, '0, '0, '0);
        beam(16'd300);
        query(hit_row, hit_col);
        drain();
    endtask

    // origin saturation, extreme ranges and headings, queries at grid edges
    task automatic test_directed();
        scan(24'h7FFFFF, 24'h7FFFFF, 16'd0);
        beam(16'd0);
        query(hit_row, hit_col);
        beam(16'hFFFF);
        beam(16'd1000);
        query(hit_row, hit_col);
        query(hit_row + 3, hit_col);
        scan(24'h800000, 24'h800000, 16'h8000);
        beam(16'd2000);
        query(hit_row, hit_col);
        scan(24'h000000, 24'hFFFFFF, 16'h7FFF);
        query(hit_row, hit_col);
        beam(16'd500);
        beam(16'd6000);
        query(hit_row, hit_col);
        query(0, GRID - 1);
        query(GRID - 1, 0);
        query(0, 255);
        drain();
    endtask

    // register extremes, zero cell size taken as one
    task automatic test_register_extremes();
        write_regs(16'd1, 16'hFFFF, 16'h7FFF, 16'hFFFF);  // whole grid marked
        scan($urandom, $urandom, $urandom);
        query(10, 20);
        beam(16'd0);
        query(10, 20);
        query(GRID - 1, GRID - 1);
        write_regs(16'hFFFF, 16'hFFFF, 16'h8000, 16'd0);
        scan(24'd0, 24'd0, 16'd0);
        beam(16'hFFFF);
        query(hit_row, hit_col);
        query(HALF - 1, HALF - 1);
        beam(16'd0);
        query(HALF, HALF);
        write_regs(16'd0, 16'd3, 16'd0, 16'd1);
        scan(24'd0, 24'd0, 16'h4000);
        beam(16'd20);
        query(hit_row, hit_col);
        beam(16'd60);
        query(hit_row, hit_col);
        write_regs(16'd200, 16'd0, 16'h0000, 16'h1000);
        scan($urandom, $urandom, $urandom);
        for (int i = 0; i < 6; i++) begin
            beam($urandom_range(0, 12000));
            query(hit_row, hit_col);
        end
        drain();
    endtask

    // random scans with beams and queries, registers changed between segments
    task automatic test_random(int items);
        int k;
        for (int n = 0; n < items; n++) begin
            if (n % 150 == 0) begin
                write_regs($urandom_range(40, 400), $urandom_range(0, 600),
                           $urandom, $urandom);
                send_busy_free = ($urandom_range(0, 3) == 0);
                recv_busy_free = ($urandom_range(0, 3) == 0);
            end
            k = $urandom_range(0, 99);
            if (k < 3 || n % 150 == 0)
                scan($urandom, $urandom, $urandom);
            else if (k < 48)
                beam(($urandom_range(0, 9) < 8) ? $urandom_range(0, 9000) : $urandom);
            else if (k < 96)
                aimed_query();
            else
                send_item(OP_NOP, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
        end
        send_busy_free = 0;
        recv_busy_free = 0;
        drain();
    endtask

    // receiver held off while queries keep coming, so the input stalls
    task automatic test_backpressure();
        send_busy_free = 1;
        recv_hold = 3000;
        for (int i = 0; i < 30; i++) aimed_query();
        send_busy_free = 0;
        drain();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_NOP;
        i_pose_x     = '0;
        i_pose_y     = '0;
        i_heading    = '0;
        i_beam_range = '0;
        i_query_row  = '0;
        i_query_col  = '0;
        grid_map     = '{default: 1'b0};
        grid_org_x   = '0;
        grid_org_y   = '0;
        scan_hdg     = '0;
        beam_idx     = '0;
        reg_cell     = CELL_SIZE_RST;
        reg_infl     = INFLATION_RST;
        reg_first    = FIRST_BEAM_RST;
        reg_step     = BEAM_STEP_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random(720);
        write_regs(CELL_SIZE_RST, INFLATION_RST, FIRST_BEAM_RST, BEAM_STEP_RST);

        repeat (200) @(posedge i_clk);
        if (occ_expected.size() != 0)
            report_mismatch("queries left unanswered");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #500_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
